// File: rtl/icmp_reply_classifier_unit_assert.svh
// ----------------------------------------------------------------------------
// icmp reply classifier assertion macros
// Concurrent checks on clk_i, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef ICMP_REPLY_CLASSIFIER_UNIT_ASSERT_SVH
`define ICMP_REPLY_CLASSIFIER_UNIT_ASSERT_SVH

`ifndef SYNTH
// check that is masked while reset is applied
`define ICR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check that also holds while reset is applied
`define ICR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ICR_ASSERT(lbl, prop, msg)
`define ICR_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// File: rtl/icr_pkg.sv
// ----------------------------------------------------------------------------
// icr_pkg
// Widths, protocol numbers and reason encoding for the icmp reply classifier.
// ----------------------------------------------------------------------------
package icr_pkg;

  // field widths
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned OFF_W    = 16;
  localparam int unsigned HDR_W    = 6;
  localparam int unsigned IDENT_W  = 16;
  localparam int unsigned REASON_W = 6;

  // packet limits
  localparam logic [OFF_W-1:0] MAX_PACKET_BYTES = 16'hFFFF;
  localparam logic [HDR_W-1:0] MIN_IP_HDR       = 6'd20;
  localparam logic [OFF_W-1:0] MIN_IP_LEN       = 16'd20;
  localparam logic [OFF_W-1:0] ICMP_HDR_BYTES   = 16'd8;
  localparam logic [OFF_W-1:0] IP6_HDR_BYTES    = 16'd40;
  localparam logic [OFF_W-1:0] V6_ERR_MIN_LEN   = 16'd56;
  localparam logic [15:0]      CSUM_GOOD        = 16'hFFFF;

  // byte positions inside headers
  localparam logic [OFF_W-1:0] IP4_PROTO_POS = 16'd9;
  localparam logic [OFF_W-1:0] IP6_NH_POS    = 16'd6;

  // protocol numbers
  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] NH_ICMPV6    = 8'd58;

  // icmpv4 types
  localparam logic [7:0] T4_ECHO_REPLY   = 8'd0;
  localparam logic [7:0] T4_UNREACH      = 8'd3;
  localparam logic [7:0] T4_QUENCH       = 8'd4;
  localparam logic [7:0] T4_REDIRECT     = 8'd5;
  localparam logic [7:0] T4_ECHO_REQUEST = 8'd8;
  localparam logic [7:0] T4_TIME_EXCEED  = 8'd11;
  localparam logic [7:0] T4_PARAM_PROB   = 8'd12;

  // icmpv6 types
  localparam logic [7:0] T6_UNREACH      = 8'd1;
  localparam logic [7:0] T6_TOO_BIG      = 8'd2;
  localparam logic [7:0] T6_TIME_EXCEED  = 8'd3;
  localparam logic [7:0] T6_PARAM_PROB   = 8'd4;
  localparam logic [7:0] T6_ECHO_REQUEST = 8'd128;
  localparam logic [7:0] T6_ECHO_REPLY   = 8'd129;

  // unreachable code for administratively prohibited
  localparam logic [7:0] C4_UNREACH_ADMIN = 8'd13;

  // reason codes
  localparam logic [REASON_W-1:0] RSN_ECHO_REPLY     = 6'd0;
  localparam logic [REASON_W-1:0] RSN4_UNREACH       = 6'd1;
  localparam logic [REASON_W-1:0] RSN4_UNREACH_ADMIN = 6'd7;
  localparam logic [REASON_W-1:0] RSN4_UNREACH_OTHER = 6'd8;
  localparam logic [REASON_W-1:0] RSN4_TIME_EXCEED   = 6'd9;
  localparam logic [REASON_W-1:0] RSN4_TIME_OTHER    = 6'd11;
  localparam logic [REASON_W-1:0] RSN4_PARAM_PROB    = 6'd12;
  localparam logic [REASON_W-1:0] RSN4_QUENCH        = 6'd13;
  localparam logic [REASON_W-1:0] RSN4_REDIRECT      = 6'd14;
  localparam logic [REASON_W-1:0] RSN4_REDIRECT_OTH  = 6'd18;
  localparam logic [REASON_W-1:0] RSN6_UNREACH       = 6'd19;
  localparam logic [REASON_W-1:0] RSN6_UNREACH_OTHER = 6'd24;
  localparam logic [REASON_W-1:0] RSN6_TOO_BIG       = 6'd25;
  localparam logic [REASON_W-1:0] RSN6_TIME_EXCEED   = 6'd26;
  localparam logic [REASON_W-1:0] RSN6_TIME_OTHER    = 6'd28;
  localparam logic [REASON_W-1:0] RSN6_PARAM_PROB    = 6'd29;
  localparam logic [REASON_W-1:0] RSN6_PARAM_OTHER   = 6'd32;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_ECHO_IDENT  = 1'b0,
    CFG_ADDR_FAMILY = 1'b1
  } cfg_reg_e;

  // reason for an icmpv4 error message
  function automatic logic [REASON_W-1:0] reason_v4(logic [7:0] t, logic [7:0] c);
    logic [REASON_W-1:0] r;
    r = RSN_ECHO_REPLY;
    case (t)
      T4_UNREACH: begin
        if (c <= 8'd5) r = RSN4_UNREACH + c[REASON_W-1:0];
        else if (c == C4_UNREACH_ADMIN) r = RSN4_UNREACH_ADMIN;
        else r = RSN4_UNREACH_OTHER;
      end
      T4_TIME_EXCEED: begin
        if (c <= 8'd1) r = RSN4_TIME_EXCEED + c[REASON_W-1:0];
        else r = RSN4_TIME_OTHER;
      end
      T4_PARAM_PROB: r = RSN4_PARAM_PROB;
      T4_QUENCH:     r = RSN4_QUENCH;
      T4_REDIRECT: begin
        if (c <= 8'd3) r = RSN4_REDIRECT + c[REASON_W-1:0];
        else r = RSN4_REDIRECT_OTH;
      end
      default: r = RSN_ECHO_REPLY;
    endcase
    return r;
  endfunction

  // reason for an icmpv6 error message
  function automatic logic [REASON_W-1:0] reason_v6(logic [7:0] t, logic [7:0] c);
    logic [REASON_W-1:0] r;
    r = RSN_ECHO_REPLY;
    case (t)
      T6_UNREACH: begin
        if (c <= 8'd4) r = RSN6_UNREACH + c[REASON_W-1:0];
        else r = RSN6_UNREACH_OTHER;
      end
      T6_TOO_BIG: r = RSN6_TOO_BIG;
      T6_TIME_EXCEED: begin
        if (c <= 8'd1) r = RSN6_TIME_EXCEED + c[REASON_W-1:0];
        else r = RSN6_TIME_OTHER;
      end
      T6_PARAM_PROB: begin
        if (c <= 8'd2) r = RSN6_PARAM_PROB + c[REASON_W-1:0];
        else r = RSN6_PARAM_OTHER;
      end
      default: r = RSN_ECHO_REPLY;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/icmp_reply_classifier_unit.sv
// ----------------------------------------------------------------------------
// icmp_reply_classifier_unit
// Byte-wise classifier of icmp echo replies and of error messages around an echo request, for ipv4 and raw icmpv6.
// ----------------------------------------------------------------------------
// Usage:
//   Packet bytes enter on the in_* valid/ready channel, one byte per request,
//   with last_byte_i marking the final byte. Each packet gives one verdict on
//   the out_* valid/ready channel: accepted, host id, sequence byte, reason.
//   cfg_we_i writes echo_ident (index 0) or address_family (index 1); write
//   only while no packet is in flight.
//   Throughput: one byte per cycle while no last byte waits on a pending
//   verdict. Each byte is registered at the input, then a single pass of
//   compare, capture and checksum add updates the packet state and, for the
//   last byte, loads the result register. The last byte is thus captured in
//   the input register and its verdict then in the result register.
//   Stall: while a verdict waits in the result register, bytes that are not
//   last keep flowing; a new last byte waits in the input register until the
//   verdict is taken, and ready drops behind it.
//   Reset: clears the valid bits of both registers, the packet state and the
//   configuration (echo_ident 0, ipv4 mode); no result is pending after reset.
// ----------------------------------------------------------------------------
`include "icmp_reply_classifier_unit_assert.svh"

module icmp_reply_classifier_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic                           cfg_addr_i,
  input  logic [icr_pkg::IDENT_W-1:0]    cfg_wdata_i,
  // byte stream
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [icr_pkg::DATA_W-1:0]     data_byte_i,
  input  logic                           last_byte_i,
  // verdict
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           accepted_o,
  output logic [7:0]                     host_id_o,
  output logic [7:0]                     seq_number_o,
  output logic [icr_pkg::REASON_W-1:0]   reason_o
);

  // configuration registers
  logic [icr_pkg::IDENT_W-1:0] ident_q;
  logic                        v6_q;

  // input register
  logic                        in_vld_q;
  logic [icr_pkg::DATA_W-1:0]  in_data_q;
  logic                        in_last_q;

  // packet state
  logic [icr_pkg::OFF_W-1:0]   off_q, off_d;
  logic [icr_pkg::HDR_W-1:0]   hl_q, hl_d;
  logic [7:0]                  proto_q, proto_d;
  logic [15:0]                 sum_q, sum_d;
  logic [7:0]                  pend_q, pend_d;
  logic [15:0]                 tc_q, tc_d;
  logic [31:0]                 idseq_q, idseq_d;
  logic [7:0]                  iproto_q, iproto_d;
  logic [icr_pkg::HDR_W-1:0]   ihl_q, ihl_d;
  logic [7:0]                  itype_q, itype_d;
  logic [31:0]                 iid_q, iid_d;

  // byte decode
  logic                        taken;
  logic                        icmp_act;
  logic                        sum_act;
  logic                        inner_act;
  logic                        inner_body;
  logic                        add_word;
  logic [icr_pkg::OFF_W-1:0]   rel;
  logic [icr_pkg::OFF_W-1:0]   idx_i;
  logic [icr_pkg::OFF_W-1:0]   idx_j;
  logic [15:0]                 addend;
  logic [16:0]                 sum_raw;

  // verdict
  logic                        ok;
  logic [15:0]                 seq;
  logic [icr_pkg::REASON_W-1:0] why;
  logic [icr_pkg::OFF_W-1:0]   hl_ext;
  logic [icr_pkg::OFF_W-1:0]   ihl_ext;

  // result register
  logic                        out_vld_q;
  logic                        acc_q;
  logic [15:0]                 seq_q;
  logic [icr_pkg::REASON_W-1:0] why_q;

  // handshake
  logic                        out_free;
  logic                        proc;

  assign out_free   = !out_vld_q || out_ready_i;
  assign proc       = in_vld_q && (!in_last_q || out_free);
  assign in_ready_o = !in_vld_q || proc;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_q <= '0;
      v6_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        icr_pkg::CFG_ECHO_IDENT:  ident_q <= cfg_wdata_i;
        icr_pkg::CFG_ADDR_FAMILY: v6_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  // per-byte decode: header capture, field capture and checksum
  always_comb begin
    proto_d  = proto_q;
    pend_d   = pend_q;
    tc_d     = tc_q;
    idseq_d  = idseq_q;
    iproto_d = iproto_q;
    itype_d  = itype_q;
    iid_d    = iid_q;

    taken = off_q < icr_pkg::MAX_PACKET_BYTES;
    off_d = taken ? off_q + 16'd1 : off_q;

    // outer ipv4 header
    hl_d = (taken && !v6_q && off_q == '0) ? {in_data_q[3:0], 2'b00} : hl_q;
    if (taken && !v6_q && off_q == icr_pkg::IP4_PROTO_POS) proto_d = in_data_q;
    hl_ext = {{(icr_pkg::OFF_W-icr_pkg::HDR_W){1'b0}}, hl_d};

    // outer icmp part
    rel      = v6_q ? off_q : off_q - hl_ext;
    icmp_act = taken && (v6_q || (hl_d >= icr_pkg::MIN_IP_HDR && off_q >= hl_ext));
    sum_act  = icmp_act && !v6_q;
    if (sum_act && !rel[0]) pend_d = in_data_q;
    if (icmp_act) begin
      if (rel == 16'd0) tc_d[15:8] = in_data_q;
      if (rel == 16'd1) tc_d[7:0]  = in_data_q;
      if (rel >= 16'd4 && rel <= 16'd7) idseq_d = {idseq_q[23:0], in_data_q};
    end

    // embedded original header
    idx_i     = rel - icr_pkg::ICMP_HDR_BYTES;
    inner_act = icmp_act && rel >= icr_pkg::ICMP_HDR_BYTES;
    ihl_d     = (inner_act && !v6_q && idx_i == '0) ? {in_data_q[3:0], 2'b00} : ihl_q;
    ihl_ext   = {{(icr_pkg::OFF_W-icr_pkg::HDR_W){1'b0}}, ihl_d};
    if (inner_act && idx_i == (v6_q ? icr_pkg::IP6_NH_POS : icr_pkg::IP4_PROTO_POS))
      iproto_d = in_data_q;

    // embedded echo request
    idx_j      = v6_q ? idx_i - icr_pkg::IP6_HDR_BYTES : idx_i - ihl_ext;
    inner_body = inner_act && (v6_q ? idx_i >= icr_pkg::IP6_HDR_BYTES
                                    : (ihl_d >= icr_pkg::MIN_IP_HDR && idx_i >= ihl_ext));
    if (inner_body) begin
      if (idx_j == 16'd0) itype_d = in_data_q;
      if (idx_j >= 16'd4 && idx_j <= 16'd7) iid_d = {iid_q[23:0], in_data_q};
    end

    // one's-complement add; on the last byte an odd tail is padded with zero
    add_word = sum_act && rel[0];
    if (add_word) addend = {pend_q, in_data_q};
    else if (in_last_q && off_d[0]) addend = {pend_d, 8'h00};
    else addend = '0;
    sum_raw = {1'b0, sum_q} + {1'b0, addend};
    sum_d   = sum_raw[15:0] + {15'b0, sum_raw[16]};
  end

  // verdict on the state after the last byte
  always_comb begin
    ok  = 1'b0;
    seq = '0;
    why = icr_pkg::RSN_ECHO_REPLY;
    if (!v6_q) begin
      if (hl_d >= icr_pkg::MIN_IP_HDR && proto_d == icr_pkg::PROTO_ICMP &&
          off_d >= icr_pkg::MIN_IP_LEN && off_d >= hl_ext + icr_pkg::ICMP_HDR_BYTES &&
          sum_d == icr_pkg::CSUM_GOOD) begin
        if (tc_d[15:8] == icr_pkg::T4_ECHO_REPLY) begin
          if (idseq_d[31:16] == ident_q) begin
            ok  = 1'b1;
            seq = idseq_d[15:0];
          end
        end else if (tc_d[15:8] == icr_pkg::T4_UNREACH ||
                     tc_d[15:8] == icr_pkg::T4_QUENCH ||
                     tc_d[15:8] == icr_pkg::T4_REDIRECT ||
                     tc_d[15:8] == icr_pkg::T4_TIME_EXCEED ||
                     tc_d[15:8] == icr_pkg::T4_PARAM_PROB) begin
          if (off_d >= hl_ext + icr_pkg::ICMP_HDR_BYTES + icr_pkg::MIN_IP_LEN &&
              ihl_d >= icr_pkg::MIN_IP_HDR && iproto_d == icr_pkg::PROTO_ICMP &&
              off_d >= hl_ext + ihl_ext + icr_pkg::ICMP_HDR_BYTES + icr_pkg::ICMP_HDR_BYTES &&
              itype_d == icr_pkg::T4_ECHO_REQUEST && iid_d[31:16] == ident_q) begin
            ok  = 1'b1;
            seq = iid_d[15:0];
            why = icr_pkg::reason_v4(tc_d[15:8], tc_d[7:0]);
          end
        end
      end
    end else if (off_d >= icr_pkg::ICMP_HDR_BYTES) begin
      if (tc_d[15:8] == icr_pkg::T6_ECHO_REPLY) begin
        if (idseq_d[31:16] == ident_q) begin
          ok  = 1'b1;
          seq = idseq_d[15:0];
        end
      end else if (tc_d[15:8] >= icr_pkg::T6_UNREACH &&
                   tc_d[15:8] <= icr_pkg::T6_PARAM_PROB) begin
        if (off_d >= icr_pkg::V6_ERR_MIN_LEN && iproto_d == icr_pkg::NH_ICMPV6 &&
            itype_d == icr_pkg::T6_ECHO_REQUEST && iid_d[31:16] == ident_q) begin
          ok  = 1'b1;
          seq = iid_d[15:0];
          why = icr_pkg::reason_v6(tc_d[15:8], tc_d[7:0]);
        end
      end
    end
  end

  // packet state, cleared after each last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q    <= '0;
      hl_q     <= '0;
      proto_q  <= '0;
      sum_q    <= '0;
      pend_q   <= '0;
      tc_q     <= '0;
      idseq_q  <= '0;
      iproto_q <= '0;
      ihl_q    <= '0;
      itype_q  <= '0;
      iid_q    <= '0;
    end else if (proc) begin
      if (in_last_q) begin
        off_q    <= '0;
        hl_q     <= '0;
        proto_q  <= '0;
        sum_q    <= '0;
        pend_q   <= '0;
        tc_q     <= '0;
        idseq_q  <= '0;
        iproto_q <= '0;
        ihl_q    <= '0;
        itype_q  <= '0;
        iid_q    <= '0;
      end else begin
        off_q    <= off_d;
        hl_q     <= hl_d;
        proto_q  <= proto_d;
        sum_q    <= sum_d;
        pend_q   <= pend_d;
        tc_q     <= tc_d;
        idseq_q  <= idseq_d;
        iproto_q <= iproto_d;
        ihl_q    <= ihl_d;
        itype_q  <= itype_d;
        iid_q    <= iid_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && in_last_q) begin
      acc_q <= ok;
      seq_q <= seq;
      why_q <= why;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign accepted_o   = acc_q;
  assign host_id_o    = seq_q[15:8];
  assign seq_number_o = seq_q[7:0];
  assign reason_o     = why_q;

  // checks
  `ICR_ASSERT_RST(a_reset_no_result, !rst_ni |-> !out_valid_o, "result valid during reset")
  `ICR_ASSERT(a_result_from_last, $rose(out_valid_o) |-> $past(in_vld_q && in_last_q), "result without last byte")
  `ICR_ASSERT(a_reject_zero, out_valid_o && !accepted_o |-> host_id_o == '0 && seq_number_o == '0 && reason_o == '0, "rejected result not zero")
  `ICR_ASSERT(a_state_cleared, proc && in_last_q |=> off_q == '0 && sum_q == '0, "packet state not cleared")

endmodule

// File: tb/tb_icmp_reply_classifier_unit.sv
// ----------------------------------------------------------------------------
// tb_icmp_reply_classifier_unit
// Streams ipv4 and raw icmpv6 packets byte by byte into the classifier and
// checks every verdict against a cycle-free model of the packet parser kept
// here. Directed packets cover echo replies, every error type and code group,
// header and length rejects, config changes inside a packet and an overlong
// packet. Random packets follow under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_icmp_reply_classifier_unit;
  import icr_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT  = 4;

  typedef struct packed {
    logic                accepted;
    logic [7:0]          host_id;
    logic [7:0]          seq_number;
    logic [REASON_W-1:0] reason;
  } verdict_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_addr_i  = 1'b0;
  logic [IDENT_W-1:0]  cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [DATA_W-1:0]   data_byte_i = '0;
  logic                last_byte_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                accepted_o;
  logic [7:0]          host_id_o;
  logic [7:0]          seq_number_o;
  logic [REASON_W-1:0] reason_o;

  icmp_reply_classifier_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .accepted_o   (accepted_o),
    .host_id_o    (host_id_o),
    .seq_number_o (seq_number_o),
    .reason_o     (reason_o)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  int          errors    = 0;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  verdict_t    verdict_q[$];
  logic [7:0]  pkt_q[$];

  // configuration mirror
  logic [15:0] cur_ident  = '0;
  logic        cur_family = 1'b0;

  // parser state mirror
  int unsigned rx_count      = 0;
  logic [5:0]  hdr4_bytes    = '0;
  logic [7:0]  proto4        = '0;
  logic [15:0] csum_acc      = '0;
  logic [7:0]  hi_byte       = '0;
  logic [15:0] type_code     = '0;
  logic [31:0] outer_word    = '0;
  logic [7:0]  emb_proto     = '0;
  logic [5:0]  emb_hdr_bytes = '0;
  logic [7:0]  emb_type      = '0;
  logic [31:0] emb_word      = '0;

  // end-around-carry add of one 16-bit word
  function automatic logic [15:0] ones_add(logic [15:0] acc, logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic logic [REASON_W-1:0] v4_error_reason(logic [7:0] t, logic [7:0] c);
    case (t)
      T4_UNREACH: begin
        if (c <= 8'd5) return RSN4_UNREACH + c[REASON_W-1:0];
        return (c == C4_UNREACH_ADMIN) ? RSN4_UNREACH_ADMIN : RSN4_UNREACH_OTHER;
      end
      T4_TIME_EXCEED: return (c <= 8'd1) ? RSN4_TIME_EXCEED + c[REASON_W-1:0] : RSN4_TIME_OTHER;
      T4_PARAM_PROB:  return RSN4_PARAM_PROB;
      T4_QUENCH:      return RSN4_QUENCH;
      T4_REDIRECT:    return (c <= 8'd3) ? RSN4_REDIRECT + c[REASON_W-1:0] : RSN4_REDIRECT_OTH;
      default:        return RSN_ECHO_REPLY;
    endcase
  endfunction

  function automatic logic [REASON_W-1:0] v6_error_reason(logic [7:0] t, logic [7:0] c);
    case (t)
      T6_UNREACH:     return (c <= 8'd4) ? RSN6_UNREACH + c[REASON_W-1:0] : RSN6_UNREACH_OTHER;
      T6_TOO_BIG:     return RSN6_TOO_BIG;
      T6_TIME_EXCEED: return (c <= 8'd1) ? RSN6_TIME_EXCEED + c[REASON_W-1:0] : RSN6_TIME_OTHER;
      T6_PARAM_PROB:  return (c <= 8'd2) ? RSN6_PARAM_PROB + c[REASON_W-1:0] : RSN6_PARAM_OTHER;
      default:        return RSN_ECHO_REPLY;
    endcase
  endfunction

  function automatic verdict_t granted(logic [15:0] sq, logic [REASON_W-1:0] rsn);
    verdict_t v;
    v.accepted   = 1'b1;
    v.host_id    = sq[15:8];
    v.seq_number = sq[7:0];
    v.reason     = rsn;
    return v;
  endfunction

  // capture one packet byte under the current mode
  task automatic decode_byte(input logic [7:0] b);
    int unsigned off, rel, i, j;
    off = rx_count;
    rel = off;
    if (!cur_family) begin
      if (off == 0) hdr4_bytes = {b[3:0], 2'b00};
      if (off == 9) proto4 = b;
      if (hdr4_bytes < 20 || off < hdr4_bytes) return;
      rel = off - hdr4_bytes;
      if (rel[0] == 1'b0) hi_byte = b;
      else csum_acc = ones_add(csum_acc, {hi_byte, b});
    end
    if (rel == 0) type_code[15:8] = b;
    if (rel == 1) type_code[7:0] = b;
    if (rel >= 4 && rel <= 7) outer_word = {outer_word[23:0], b};
    if (rel < 8) return;
    i = rel - 8;
    if (!cur_family) begin
      if (i == 0) emb_hdr_bytes = {b[3:0], 2'b00};
      if (i == 9) emb_proto = b;
      if (emb_hdr_bytes < 20 || i < emb_hdr_bytes) return;
      j = i - emb_hdr_bytes;
    end else begin
      if (i == 6) emb_proto = b;
      if (i < 40) return;
      j = i - 40;
    end
    if (j == 0) emb_type = b;
    if (j >= 4 && j <= 7) emb_word = {emb_word[23:0], b};
  endtask

  // verdict for the packet that just ended
  function automatic verdict_t judge_packet();
    verdict_t    v;
    int unsigned len, hl, body_len, inner_len, ihl;
    logic [15:0] sum;
    logic [7:0]  t, c;
    v   = '0;
    len = rx_count;
    t   = type_code[15:8];
    c   = type_code[7:0];
    if (!cur_family) begin
      hl = hdr4_bytes;
      if (hl < 20 || proto4 != PROTO_ICMP || len < 20 || len < hl + 8) return v;
      body_len = len - hl;
      sum = csum_acc;
      if (body_len % 2 == 1) sum = ones_add(sum, {hi_byte, 8'h00});
      if (sum != CSUM_GOOD) return v;
      if (t == T4_ECHO_REPLY) begin
        if (outer_word[31:16] != cur_ident) return v;
        return granted(outer_word[15:0], RSN_ECHO_REPLY);
      end
      if (t != T4_UNREACH && t != T4_QUENCH && t != T4_REDIRECT &&
          t != T4_TIME_EXCEED && t != T4_PARAM_PROB) return v;
      inner_len = body_len - 8;
      ihl = emb_hdr_bytes;
      if (inner_len < 20 || ihl < 20 || emb_proto != PROTO_ICMP || inner_len < ihl + 8)
        return v;
      if (emb_type != T4_ECHO_REQUEST || emb_word[31:16] != cur_ident) return v;
      return granted(emb_word[15:0], v4_error_reason(t, c));
    end
    if (len < 8) return v;
    if (t == T6_ECHO_REPLY) begin
      if (outer_word[31:16] != cur_ident) return v;
      return granted(outer_word[15:0], RSN_ECHO_REPLY);
    end
    if (t < T6_UNREACH || t > T6_PARAM_PROB) return v;
    if (len < V6_ERR_MIN_LEN || emb_proto != NH_ICMPV6) return v;
    if (emb_type != T6_ECHO_REQUEST || emb_word[31:16] != cur_ident) return v;
    return granted(emb_word[15:0], v6_error_reason(t, c));
  endfunction

  // model update for one accepted byte request
  task automatic predict_byte(input logic [7:0] b, input logic last);
    if (rx_count < int'(MAX_PACKET_BYTES)) begin
      decode_byte(b);
      rx_count++;
    end
    if (last) begin
      verdict_q.push_back(judge_packet());
      rx_count = 0;      hdr4_bytes = '0; proto4 = '0;    csum_acc = '0;
      hi_byte = '0;      type_code = '0;  outer_word = '0; emb_proto = '0;
      emb_hdr_bytes = '0; emb_type = '0;  emb_word = '0;
    end
  endtask

  // send one byte request, with random gaps ahead of it
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_byte(b, last);
  endtask

  // send pkt_q[lo..hi-1]; the final byte of the packet carries the last mark
  task automatic send_bytes(input int unsigned lo, input int unsigned hi);
    int unsigned k;
    for (k = lo; k < hi; k++) push_byte(pkt_q[k], k == pkt_q.size() - 1);
  endtask

  task automatic send_packet();
    send_bytes(0, pkt_q.size());
  endtask

  // stop sending and wait for every verdict, then let the pipeline empty
  task automatic settle_input();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // register write once the block is idle
  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] val);
    settle_input();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CFG_ECHO_IDENT) cur_ident = val;
    else cur_family = val[0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) pkt_q.push_back(8'($urandom));
  endtask

  task automatic push_word(input logic [15:0] id, input logic [15:0] sq);
    pkt_q.push_back(id[15:8]);
    pkt_q.push_back(id[7:0]);
    pkt_q.push_back(sq[15:8]);
    pkt_q.push_back(sq[7:0]);
  endtask

  // ipv4 header; a short ihl still gets 20 bytes so that the protocol sits at 9
  task automatic push_ip4_header(input logic [3:0] ihl, input logic [7:0] proto);
    int unsigned n, k;
    n = (ihl < 4'd5) ? 20 : ihl * 4;
    for (k = 0; k < n; k++) begin
      if (k == 0) pkt_q.push_back({4'h4, ihl});
      else if (k == 9) pkt_q.push_back(proto);
      else pkt_q.push_back(8'($urandom));
    end
  endtask

  // ipv4 packet with an icmp part that starts at base; checksum made good
  task automatic build_v4(input logic [3:0] ihl, input logic [7:0] proto,
                          input logic [7:0] t, input logic [7:0] c,
                          input logic [15:0] id, input logic [15:0] sq,
                          input bit embed, input logic [3:0] inner_ihl,
                          input logic [7:0] inner_proto, input logic [7:0] inner_type,
                          input int unsigned tail);
    int unsigned base, k;
    logic [15:0] acc;
    pkt_q.delete();
    push_ip4_header(ihl, proto);
    base = pkt_q.size();
    pkt_q.push_back(t);
    pkt_q.push_back(c);
    pkt_q.push_back(8'h00);
    pkt_q.push_back(8'h00);
    if (embed) begin
      push_random(4);
      push_ip4_header(inner_ihl, inner_proto);
      pkt_q.push_back(inner_type);
      push_random(3);
    end
    push_word(id, sq);
    push_random(tail);
    acc = '0;
    for (k = base; k < pkt_q.size(); k += 2)
      acc = ones_add(acc, {pkt_q[k], (k + 1 < pkt_q.size()) ? pkt_q[k + 1] : 8'h00});
    pkt_q[base + 2] = ~acc[15:8];
    pkt_q[base + 3] = ~acc[7:0];
  endtask

  // raw icmpv6 packet, optionally with an embedded ipv6 + icmpv6 request
  task automatic build_v6(input logic [7:0] t, input logic [7:0] c,
                          input logic [15:0] id, input logic [15:0] sq,
                          input bit embed, input logic [7:0] nh,
                          input logic [7:0] inner_type, input int unsigned tail);
    pkt_q.delete();
    pkt_q.push_back(t);
    pkt_q.push_back(c);
    push_random(2);
    if (embed) begin
      push_random(10);
      pkt_q.push_back(nh);
      push_random(33);
      pkt_q.push_back(inner_type);
      push_random(3);
    end
    push_word(id, sq);
    push_random(tail);
  endtask

  task automatic truncate_to(input int unsigned n);
    while (pkt_q.size() > n) void'(pkt_q.pop_back());
  endtask

  // well-formed ipv4 error message around our echo request
  task automatic send_v4_error(input logic [7:0] t, input logic [7:0] c);
    build_v4(4'd5, PROTO_ICMP, t, c, cur_ident, 16'($urandom), 1'b1, 4'd5,
             PROTO_ICMP, T4_ECHO_REQUEST, $urandom_range(3));
    send_packet();
  endtask

  task automatic send_v6_error(input logic [7:0] t, input logic [7:0] c);
    build_v6(t, c, cur_ident, 16'($urandom), 1'b1, NH_ICMPV6, T6_ECHO_REQUEST,
             $urandom_range(3));
    send_packet();
  endtask

  task automatic test_v4_echo_reply();
    int unsigned k;
    // reset identifier is zero
    build_v4(4'd5, PROTO_ICMP, T4_ECHO_REPLY, 8'd0, 16'h0000, 16'h0000, 1'b0, 4'd5,
             PROTO_ICMP, T4_ECHO_REQUEST, 4);
    send_packet();
    write_reg(CFG_ECHO_IDENT, 16'hBEEF);
    build_v4(4'd5, PROTO_ICMP, T4_ECHO_REPLY, 8'd0, 16'hBEEF, 16'hFFFF, 1'b0, 4'd5,
             PROTO_ICMP, T4_ECHO_REQUEST, 0);
    send_packet();
    // identifier mismatch
    build_v4(4'd5, PROTO_ICMP, T4_ECHO_REPLY, 8'd0, 16'hBEEE, 16'h1234, 1'b0, 4'd5,
             PROTO_ICMP, T4_ECHO_REQUEST, 2);
    send_packet();
    // odd icmp length, padded sum
    build_v4(4'd5, PROTO_ICMP, T4_ECHO_REPLY, 8'd7, 16'hBEEF, 16'h8001, 1'b0, 4'd5,
             PROTO_ICMP, T4_ECHO_REQUEST, 1);
    send_packet();
    // header with options, largest ihl
    build_v4(4'd15, PROTO_ICMP, T4_ECHO_REPLY, 8'd0, 16'hBEEF, 16'h00FF, 1'b0, 4'd5,
             PROTO_ICMP, T4_ECHO_REQUEST, 5);
    send_packet();
    // bad checksum
    build_v4(4'd6, PROTO_ICMP, T4_ECHO_REPLY, 8'd0, 16'hBEEF, 16'h4242, 1'b0, 4'd5,
             PROTO_ICMP, T4_ECHO_REQUEST, 6);
    pkt_q[pkt_q.size() - 1] ^= 8'h10;
    send_packet();
    // ihl below five
    for (k = 0; k < 5; k += 4) begin
      build_v4(4'(k), PROTO_ICMP, T4_ECHO_REPLY, 8'd0, 16'hBEEF, 16'h0101, 1'b0, 4'd5,
               PROTO_ICMP, T4_ECHO_REQUEST, 3);
      send_packet();
    end
    // not icmp
    build_v4(4'd5, 8'd6, T4_ECHO_REPLY, 8'd0, 16'hBEEF, 16'h0202, 1'b0, 4'd5,
             PROTO_ICMP, T4_ECHO_REQUEST, 3);
    send_packet();
    // shorter than an ip header, and shorter than header plus icmp header
    build_v4(4'd5, PROTO_ICMP, T4_ECHO_REPLY, 8'd0, 16'hBEEF, 16'h0303, 1'b0, 4'd5,
             PROTO_ICMP, T4_ECHO_REQUEST, 0);
    truncate_to(19);
    send_packet();
    build_v4(4'd5, PROTO_ICMP, T4_ECHO_REPLY, 8'd0, 16'hBEEF, 16'h0303, 1'b0, 4'd5,
             PROTO_ICMP, T4_ECHO_REQUEST, 0);
    truncate_to(27);
    send_packet();
    // single byte, all zero and all one packets
    pkt_q.delete();
    pkt_q.push_back(8'hFF);
    send_packet();
    pkt_q.delete();
    repeat (28) pkt_q.push_back(8'h00);
    send_packet();
    pkt_q.delete();
    repeat (64) pkt_q.push_back(8'hFF);
    send_packet();
  endtask

  task automatic test_v4_error_messages();
    int unsigned k;
    write_reg(CFG_ECHO_IDENT, 16'h0000);
    for (k = 0; k < 8; k++)
      send_v4_error(T4_UNREACH, (k == 6) ? C4_UNREACH_ADMIN : (k == 7) ? 8'd200 : 8'(k));
    for (k = 0; k < 3; k++) send_v4_error(T4_TIME_EXCEED, 8'(k));
    for (k = 0; k < 5; k++) send_v4_error(T4_REDIRECT, 8'(k));
    send_v4_error(T4_PARAM_PROB, 8'd1);
    send_v4_error(T4_QUENCH, 8'd0);
    // not an error type
    send_v4_error(T4_ECHO_REQUEST, 8'd0);
    // embedded packet faults
    build_v4(4'd5, PROTO_ICMP, T4_UNREACH, 8'd1, 16'h0000, 16'h1111, 1'b1, 4'd5,
             8'd17, T4_ECHO_REQUEST, 0);
    send_packet();
    build_v4(4'd5, PROTO_ICMP, T4_UNREACH, 8'd1, 16'h0000, 16'h1111, 1'b1, 4'd3,
             PROTO_ICMP, T4_ECHO_REQUEST, 0);
    send_packet();
    build_v4(4'd5, PROTO_ICMP, T4_UNREACH, 8'd1, 16'h0000, 16'h1111, 1'b1, 4'd5,
             PROTO_ICMP, T4_ECHO_REPLY, 0);
    send_packet();
    build_v4(4'd6, PROTO_ICMP, T4_UNREACH, 8'd1, 16'h0001, 16'h1111, 1'b1, 4'd7,
             PROTO_ICMP, T4_ECHO_REQUEST, 2);
    send_packet();
    // inner icmp header cut short; checksum field cleared
    build_v4(4'd5, PROTO_ICMP, T4_TIME_EXCEED, 8'd0, 16'h0000, 16'h2222, 1'b1, 4'd5,
             PROTO_ICMP, T4_ECHO_REQUEST, 0);
    truncate_to(55);
    pkt_q[22] = 8'h00;
    pkt_q[23] = 8'h00;
    send_packet();
  endtask

  task automatic test_v6_messages();
    int unsigned k;
    write_reg(CFG_ADDR_FAMILY, 16'hFFFF);
    write_reg(CFG_ECHO_IDENT, 16'hFFFF);
    build_v6(T6_ECHO_REPLY, 8'd0, 16'hFFFF, 16'hA55A, 1'b0, NH_ICMPV6, T6_ECHO_REQUEST, 0);
    send_packet();
    build_v6(T6_ECHO_REPLY, 8'd0, 16'hFFFE, 16'hA55A, 1'b0, NH_ICMPV6, T6_ECHO_REQUEST, 3);
    send_packet();
    build_v6(T6_ECHO_REPLY, 8'd0, 16'hFFFF, 16'hA55A, 1'b0, NH_ICMPV6, T6_ECHO_REQUEST, 0);
    truncate_to(7);
    send_packet();
    for (k = 0; k < 6; k++) send_v6_error(T6_UNREACH, 8'(k));
    send_v6_error(T6_TOO_BIG, 8'd9);
    for (k = 0; k < 3; k++) send_v6_error(T6_TIME_EXCEED, 8'(k));
    for (k = 0; k < 4; k++) send_v6_error(T6_PARAM_PROB, 8'(k));
    send_v6_error(8'd0, 8'd0);
    send_v6_error(8'd5, 8'd0);
    build_v6(T6_UNREACH, 8'd0, 16'hFFFF, 16'h0F0F, 1'b1, 8'd17, T6_ECHO_REQUEST, 0);
    send_packet();
    build_v6(T6_UNREACH, 8'd0, 16'hFFFF, 16'h0F0F, 1'b1, NH_ICMPV6, T6_ECHO_REPLY, 0);
    send_packet();
    build_v6(T6_UNREACH, 8'd0, 16'h7FFF, 16'h0F0F, 1'b1, NH_ICMPV6, T6_ECHO_REQUEST, 0);
    send_packet();
    build_v6(T6_UNREACH, 8'd0, 16'hFFFF, 16'h0F0F, 1'b1, NH_ICMPV6, T6_ECHO_REQUEST, 0);
    truncate_to(55);
    send_packet();
  endtask

  // mode and identifier rewritten while a packet is half way in
  task automatic test_config_mid_packet();
    write_reg(CFG_ADDR_FAMILY, 16'h0000);
    write_reg(CFG_ECHO_IDENT, 16'h5A5A);
    build_v4(4'd5, PROTO_ICMP, T4_ECHO_REPLY, 8'd0, 16'h5A5A, 16'h1357, 1'b0, 4'd5,
             PROTO_ICMP, T4_ECHO_REQUEST, 30);
    send_bytes(0, 24);
    settle_input();
    write_reg(CFG_ADDR_FAMILY, 16'h0001);
    send_bytes(24, pkt_q.size());
    settle_input();
    write_reg(CFG_ADDR_FAMILY, 16'h0000);
    build_v4(4'd5, PROTO_ICMP, T4_ECHO_REPLY, 8'd0, 16'hA5A5, 16'h2468, 1'b0, 4'd5,
             PROTO_ICMP, T4_ECHO_REQUEST, 10);
    send_bytes(0, pkt_q.size() - 1);
    settle_input();
    write_reg(CFG_ECHO_IDENT, 16'hA5A5);
    send_bytes(pkt_q.size() - 1, pkt_q.size());
  endtask

  // bytes past the size limit are dropped but the last mark still counts
  task automatic test_overlong_packet();
    build_v4(4'd5, PROTO_ICMP, T4_ECHO_REPLY, 8'd0, cur_ident, 16'hC0DE, 1'b0, 4'd5,
             PROTO_ICMP, T4_ECHO_REQUEST, int'(MAX_PACKET_BYTES) - 28);
    push_random(5);
    send_packet();
  endtask

  // one random packet, mostly well formed for the current mode
  task automatic make_random_packet();
    int unsigned pick, n;
    logic [15:0] id;
    logic [7:0]  t, c;
    logic [3:0]  ihl, inner_ihl;
    logic [7:0]  proto, inner_proto, inner_type;
    bit          v6;
    id = ($urandom_range(9) == 0) ? 16'($urandom) : cur_ident;
    c  = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(15));
    v6 = cur_family ^ ($urandom_range(19) == 0);
    pick = $urandom_range(99);
    if (pick < 15) begin
      pkt_q.delete();
      push_random($urandom_range(1, 64));
      return;
    end
    if (!v6) begin
      case ($urandom_range(6))
        0, 1: t = T4_ECHO_REPLY;
        2: t = T4_UNREACH;
        3: t = T4_TIME_EXCEED;
        4: t = T4_REDIRECT;
        5: t = ($urandom_range(1) == 0) ? T4_QUENCH : T4_PARAM_PROB;
        default: t = 8'($urandom);
      endcase
      ihl         = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(5, 6));
      inner_ihl   = ($urandom_range(9) == 0) ? 4'($urandom) : 4'd5;
      proto       = ($urandom_range(19) == 0) ? 8'($urandom) : PROTO_ICMP;
      inner_proto = ($urandom_range(19) == 0) ? 8'($urandom) : PROTO_ICMP;
      inner_type  = ($urandom_range(19) == 0) ? 8'($urandom) : T4_ECHO_REQUEST;
      build_v4(ihl, proto, t, c, id, 16'($urandom), t != T4_ECHO_REPLY, inner_ihl,
               inner_proto, inner_type, $urandom_range(12));
    end else begin
      case ($urandom_range(5))
        0, 1: t = T6_ECHO_REPLY;
        2: t = T6_UNREACH;
        3: t = T6_TIME_EXCEED;
        4: t = ($urandom_range(1) == 0) ? T6_TOO_BIG : T6_PARAM_PROB;
        default: t = 8'($urandom);
      endcase
      inner_proto = ($urandom_range(19) == 0) ? 8'($urandom) : NH_ICMPV6;
      inner_type  = ($urandom_range(19) == 0) ? 8'($urandom) : T6_ECHO_REQUEST;
      build_v6(t, c, id, 16'($urandom), t != T6_ECHO_REPLY, inner_proto, inner_type,
               $urandom_range(12));
    end
    // broken packets: a flipped byte or a cut tail
    if (pick < 22) begin
      n = $urandom_range(pkt_q.size() - 1);
      pkt_q[n] ^= 8'($urandom_range(1, 255));
    end else if (pick < 30) begin
      truncate_to($urandom_range(1, pkt_q.size() - 1));
    end
  endtask

  task automatic test_random_traffic(input int unsigned sender_idle,
                                     input int unsigned receiver_stall);
    int unsigned k;
    settle_input();
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    case ($urandom_range(2))
      0: write_reg(CFG_ECHO_IDENT, 16'h0000);
      1: write_reg(CFG_ECHO_IDENT, 16'hFFFF);
      default: write_reg(CFG_ECHO_IDENT, 16'($urandom));
    endcase
    write_reg(CFG_ADDR_FAMILY, 16'($urandom));
    for (k = 0; k < 14; k++) begin
      // occasional hold-off until the pipeline is empty, sometimes with a new setting
      if ($urandom_range(9) == 0) begin
        settle_input();
        if ($urandom_range(1) == 0) write_reg(CFG_ADDR_FAMILY, 16'($urandom));
        else write_reg(CFG_ECHO_IDENT, 16'($urandom));
      end else if ($urandom_range(14) == 0) begin
        settle_input();
      end
      make_random_packet();
      send_packet();
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // verdict checker and receiver stall
  always @(posedge clk_i) begin : verdict_check
    verdict_t want;
    if (out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        $error("verdict with no packet pending");
        errors++;
      end else begin
        want = verdict_q.pop_front();
        check_field("accepted", {7'd0, want.accepted}, {7'd0, accepted_o});
        check_field("host_id", want.host_id, host_id_o);
        check_field("seq_number", want.seq_number, seq_number_o);
        check_field("reason", {2'd0, want.reason}, {2'd0, reason_o});
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles with no request moving on either side
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_icmp_reply_classifier_unit: FAIL");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_v4_echo_reply();
    test_v4_error_messages();
    test_v6_messages();
    test_config_mid_packet();
    test_overlong_packet();
    test_random_traffic(0, 0);
    test_random_traffic(79, 0);
    test_random_traffic(0, 79);
    test_random_traffic(34, 34);
    settle_input();
    repeat (8) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      $error("%0d verdicts never arrived", verdict_q.size());
      errors++;
    end
    if (errors == 0) $display("tb_icmp_reply_classifier_unit: PASS");
    else $display("tb_icmp_reply_classifier_unit: FAIL");
    $finish;
  end

endmodule
